// ----- design/utf8_byte_stream_decoder_top_macros.svh -----
// Assertion macros shared by the UTF-8 decoder top level.
`ifndef UTF8_BYTE_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8DEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8dec: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8DEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8dec: next-cycle check failed");

`endif

// ----- design/u8dec_pkg.sv -----
// Package with types and constants for the UTF-8 byte stream decoder.
`timescale 1ns / 1ps

package u8dec_pkg;

  // Error marker emitted for malformed input ('?').
  localparam logic [15:0] ERR_MARK = 16'h003F;

  // Byte classification boundaries.
  localparam logic [7:0] ASCII_LIMIT   = 8'h80;
  localparam logic [7:0] LEAD_BAD_LO   = 8'hC0;
  localparam logic [7:0] LEAD_BAD_HI   = 8'hC1;
  localparam logic [7:0] LEAD_THREE    = 8'hE0;
  localparam logic [7:0] LEAD_FOUR     = 8'hF0;
  localparam logic [7:0] LEAD_TOO_HIGH = 8'hF5;

  // Payload masks for lead and continuation bytes.
  localparam logic [7:0] MASK_LEAD2 = 8'h1F;
  localparam logic [7:0] MASK_LEAD3 = 8'h0F;
  localparam logic [7:0] MASK_LEAD4 = 8'h07;
  localparam logic [7:0] MASK_CONT  = 8'h3F;

  // Pending continuation counts.
  localparam logic [1:0] REM_NONE  = 2'd0;
  localparam logic [1:0] REM_ONE   = 2'd1;
  localparam logic [1:0] REM_TWO   = 2'd2;
  localparam logic [1:0] REM_THREE = 2'd3;

  // Decode result of one byte, handed from the core to the output stage.
  typedef struct packed {
    logic        emit;
    logic [15:0] code;
  } dec_result_t;

endpackage

// ----- design/u8dec_core.sv -----
// Decode logic and sequence state for one byte per cycle, advancing only on fire_i.
`timescale 1ns / 1ps

module u8dec_core import u8dec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  byte_i,
  input  logic        fire_i,
  output dec_result_t result_o
);

  logic [1:0]  rem_q, rem_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] acc_shift;

  // Accumulator with the next six payload bits shifted in.
  assign acc_shift = {acc_q[9:0], byte_i[5:0]};

  // Classify the byte and work out the result and next state.
  always_comb begin
    rem_d         = rem_q;
    acc_d         = acc_q;
    result_o.emit = 1'b0;
    result_o.code = ERR_MARK;
    if (byte_i < ASCII_LIMIT) begin
      rem_d         = REM_NONE;
      acc_d         = '0;
      result_o.emit = 1'b1;
      result_o.code = {8'h00, byte_i};
    end else if (byte_i[7:6] != 2'b10) begin
      if (rem_q != REM_NONE) begin
        // A lead in the middle of a sequence aborts it with an error mark and is dropped.
        rem_d         = REM_NONE;
        acc_d         = '0;
        result_o.emit = 1'b1;
      end else if (byte_i == LEAD_BAD_LO || byte_i == LEAD_BAD_HI ||
                   byte_i >= LEAD_TOO_HIGH) begin
        result_o.emit = 1'b1;
      end else if (byte_i < LEAD_THREE) begin
        rem_d = REM_ONE;
        acc_d = {8'h00, byte_i & MASK_LEAD2};
      end else if (byte_i < LEAD_FOUR) begin
        rem_d = REM_TWO;
        acc_d = {8'h00, byte_i & MASK_LEAD3};
      end else begin
        rem_d = REM_THREE;
        acc_d = {8'h00, byte_i & MASK_LEAD4};
      end
    end else if (rem_q != REM_NONE) begin
      // Continuation byte; the last one of a sequence emits the low 16 bits of the code point.
      rem_d = rem_q - REM_ONE;
      if (rem_q == REM_ONE) begin
        acc_d         = '0;
        result_o.emit = 1'b1;
        result_o.code = acc_shift;
      end else begin
        acc_d = acc_shift;
      end
    end
  end

  // Sequence state advances only when the byte leaves the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= REM_NONE;
      acc_q <= '0;
    end else if (fire_i) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

endmodule

// ----- design/u8dec_outreg.sv -----
// Output register holding one decoded code point until it is taken.
`timescale 1ns / 1ps

module u8dec_outreg import u8dec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [15:0] code_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [15:0] code_o,
  output logic        free_o
);

  logic        valid_q;
  logic [15:0] code_q;

  // The slot can take a new beat when empty or when drained this cycle.
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign code_o      = code_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      code_q <= code_i;
    end
  end

endmodule

// ----- design/utf8_byte_stream_decoder_top.sv -----
// Top level of the UTF-8 byte stream decoder.
// A byte is held in the input register, decoded combinationally, and its result is
// loaded into the output register once that slot is free; it waits there until taken.
// Throughput: one byte per cycle unless a result finds the output register full; the
// decode between the input register and the output register is combinational.
// Reset (async, active low) clears both stage valid flags and the pending
// sequence state; no clearing pass is needed.
`timescale 1ns / 1ps
`include "utf8_byte_stream_decoder_top_macros.svh"

module utf8_byte_stream_decoder_top import u8dec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_point_o
);

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_fire;
  logic        out_free;
  dec_result_t res;

  // A byte leaves the input stage unless its result finds the output full.
  assign s1_fire    = s1_valid_q && (!res.emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // Input stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
    end
  end

  u8dec_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (s1_byte_q),
    .fire_i   (s1_fire),
    .result_o (res)
  );

  u8dec_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire && res.emit),
    .code_i      (res.code),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .code_o      (code_point_o),
    .free_o      (out_free)
  );

  // An ASCII byte leaving the input stage shows up unchanged at the output.
  `U8DEC_ASSERT_NEXT(a_ascii_pass, clk_i, rst_ni, s1_fire && (s1_byte_q < ASCII_LIMIT), out_valid_o && (code_point_o == {8'h00, $past(s1_byte_q)}))
  // Back-pressure at the input only comes from a held input stage.
  `U8DEC_ASSERT_NOW(a_ready_hold, clk_i, rst_ni, !in_ready_o, s1_valid_q && out_valid_o && !out_ready_i)

endmodule
